/* hw/rtl/a85_pkg.sv */
// shared types and constants of the ascii85 stream decoder
`timescale 1ns / 1ps

package a85_pkg;

   localparam logic [7:0]  DIGIT_BIAS = 8'd33;
   localparam logic [7:0]  ZERO_CHAR  = 8'h7A;
   localparam logic [31:0] RADIX      = 32'd85;
   localparam logic [2:0]  GROUP_CHARS = 3'd5;
   localparam logic [1:0]  LAST_BYTE  = 2'd3;

   localparam logic MODE_CHAR  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // one decoded group waiting to be sent as bytes
   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  last_idx;
   } group_type;

   // word handed from the front to the queue
   typedef struct packed {
      logic      push;
      group_type group;
   } push_type;

   // queue state seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // 85 to the power of the number of pad digits
   function automatic logic [31:0] pad_scale(input logic [2:0] pads);
      logic [31:0] s;
      begin
         case (pads)
            3'd1:    s = 32'd85;
            3'd2:    s = 32'd7225;
            3'd3:    s = 32'd614125;
            3'd4:    s = 32'd52200625;
            default: s = 32'd1;
         endcase
         return s;
      end
   endfunction

endpackage

/* hw/rtl/a85_channels.sv */
// stream channel interfaces for characters in and bytes out
`timescale 1ns / 1ps

interface a85_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] char_code;

   modport source (output valid, output mode, output char_code, input ready);
   modport sink (input valid, input mode, input char_code, output ready);
endinterface

interface a85_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_of_run;

   modport source (output valid, output data_byte, output last_of_run, input ready);
   modport sink (input valid, input data_byte, input last_of_run, output ready);
endinterface

/* hw/rtl/a85_front.sv */
// front end: accepts characters, keeps the base-85 accumulator, forms groups
`timescale 1ns / 1ps

module a85_front (
   input  logic                    clock,
   input  logic                    reset,
   a85_req_if.sink                 req_if,
   input  a85_pkg::queue_stat_type stat,
   output a85_pkg::push_type       push_out
);

   logic [31:0] acc_ff, acc_in;
   logic [2:0]  count_ff, count_in;
   logic        accept;
   logic [31:0] digit;
   logic [31:0] acc_next;
   logic [31:0] padded;
   logic [2:0]  count_next;
   logic [63:0] prod_digit;
   logic [63:0] prod_pad;

   assign req_if.ready = ~stat.full;
   assign accept = req_if.valid & req_if.ready;

   assign digit      = {24'd0, req_if.char_code} - {24'd0, a85_pkg::DIGIT_BIAS};
   assign prod_digit = {32'd0, acc_ff} * {32'd0, a85_pkg::RADIX};
   assign acc_next   = prod_digit[31:0] + digit;
   assign count_next = count_ff + 3'd1;

   // padding with digit 84 up to five gives (acc + 1) * 85^pads - 1
   assign prod_pad = {32'd0, acc_ff + 32'd1}
                     * {32'd0, a85_pkg::pad_scale(a85_pkg::GROUP_CHARS - count_ff)};
   assign padded   = prod_pad[31:0] - 32'd1;

   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      push_out = '0;
      if (accept) begin
         if (req_if.mode == a85_pkg::MODE_FLUSH) begin
            acc_in   = '0;
            count_in = '0;
            if (count_ff >= 3'd2) begin
               push_out.push           = 1'b1;
               push_out.group.value    = padded;
               push_out.group.last_idx = count_ff[1:0] - 2'd2;
            end
         end else if (req_if.char_code == a85_pkg::ZERO_CHAR) begin
            acc_in   = '0;
            count_in = '0;
            push_out.push           = 1'b1;
            push_out.group.value    = '0;
            push_out.group.last_idx = a85_pkg::LAST_BYTE;
         end else if (count_next == a85_pkg::GROUP_CHARS) begin
            acc_in   = '0;
            count_in = '0;
            push_out.push           = 1'b1;
            push_out.group.value    = acc_next;
            push_out.group.last_idx = a85_pkg::LAST_BYTE;
         end else begin
            acc_in   = acc_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/a85_queue.sv */
// short group queue between front and back
`timescale 1ns / 1ps

module a85_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  a85_pkg::push_type       push_in,
   input  logic                    pop,
   output a85_pkg::group_type      head,
   output a85_pkg::queue_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   a85_pkg::group_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign do_push = push_in.push & ~stat.full;
   assign do_pop  = pop & ~stat.empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_in.group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/a85_back.sv */
// back end: sends each queued group as big-endian bytes
`timescale 1ns / 1ps

module a85_back (
   input  logic                    clock,
   input  logic                    reset,
   input  a85_pkg::group_type      head,
   input  a85_pkg::queue_stat_type stat,
   output logic                    pop,
   a85_rsp_if.source               rsp_if
);

   logic [1:0] idx_ff, idx_in;
   logic       sent;
   logic       last;

   assign rsp_if.valid = ~stat.empty;
   assign last = (idx_ff == head.last_idx);
   assign rsp_if.last_of_run = last;
   assign sent = rsp_if.valid & rsp_if.ready;
   assign pop  = sent & last;

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_if.data_byte = head.value[31:24];
         2'd1:    rsp_if.data_byte = head.value[23:16];
         2'd2:    rsp_if.data_byte = head.value[15:8];
         default: rsp_if.data_byte = head.value[7:0];
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (sent) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* hw/rtl/ascii85_stream_decoder.sv */
// top level of the ascii85 stream decoder
`timescale 1ns / 1ps
//
// req_if takes one word per cycle if ready: an ascii85 character (mode 0) or an
// end-of-stream marker (mode 1) that flushes a partial group padded with 'u'.
// rsp_if gives decoded bytes, most significant first, with last_of_run set
// on the final byte that one request word caused.
// the front keeps the base-85 accumulator and takes a character every cycle
// while the group queue has room; one multiply by 85 per character sets that.
// a finished group (five characters, 'z', or a flush after two or more) enters
// the queue in the cycle it is accepted; its bytes go out on rsp_if one a cycle
// while ready holds, so the byte port sets the rate at up to four bytes a group.
// when the receiver stalls, groups build up in the queue of QUEUE_DEPTH entries
// and req_if.ready drops only once the queue is full.
// synchronous reset clears the accumulator, character count and queue; no
// bytes are pending afterwards.
//
module ascii85_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   a85_req_if.sink   req_if,
   a85_rsp_if.source rsp_if
);

   a85_pkg::push_type       push;
   a85_pkg::group_type      head;
   a85_pkg::queue_stat_type stat;
   logic                    pop;

   a85_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .stat     (stat),
      .push_out (push)
   );

   a85_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .stat    (stat)
   );

   a85_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .stat   (stat),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

/* dv/ascii85_stream_decoder_tb.sv */
// self-checking testbench for the ascii85 stream decoder
`timescale 1ns / 1ps

module ascii85_stream_decoder_tb;

   localparam logic [31:0] PAD_DIGIT   = 32'd84;
   localparam int          QUIET_LIMIT = 2000;
   localparam int          TAIL_CYCLES = 20;

   typedef struct {
      logic       mode;
      logic [7:0] char_code;
   } char_word_type;

   typedef struct {
      logic [7:0] data_byte;
      logic       last_of_run;
   } byte_word_type;

   logic clock;
   logic reset;

   a85_req_if req_if ();
   a85_rsp_if rsp_if ();

   ascii85_stream_decoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   char_word_type char_words[$];
   byte_word_type expected_bytes[$];
   logic [31:0]   group_acc;
   logic [2:0]    group_cnt;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            error_count;
   int            quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // queue the first n bytes of a group value, most significant first
   function automatic void push_group_bytes(input logic [31:0] value, input int n);
      logic [31:0]   v;
      byte_word_type b;
      v = value;
      for (int i = 0; i < n; i++) begin
         b.data_byte   = v[31:24];
         b.last_of_run = (i == n - 1);
         expected_bytes.push_back(b);
         v = v << 8;
      end
   endfunction

   function automatic void decode_word(input char_word_type w);
      logic [31:0] v;
      int          j;
      if (w.mode == a85_pkg::MODE_FLUSH) begin
         // partial group is padded with 'u' and loses one byte
         if (group_cnt != 3'd0) begin
            v = group_acc;
            for (j = int'(group_cnt); j < int'(a85_pkg::GROUP_CHARS); j++) begin
               v = v * a85_pkg::RADIX + PAD_DIGIT;
            end
            push_group_bytes(v, int'(group_cnt) - 1);
         end
         group_acc = '0;
         group_cnt = '0;
      end else if (w.char_code == a85_pkg::ZERO_CHAR) begin
         // pending characters are dropped
         group_acc = '0;
         group_cnt = '0;
         push_group_bytes(32'd0, 4);
      end else begin
         group_acc = group_acc * a85_pkg::RADIX
                     + ({24'd0, w.char_code} - {24'd0, a85_pkg::DIGIT_BIAS});
         group_cnt = group_cnt + 3'd1;
         if (group_cnt == a85_pkg::GROUP_CHARS) begin
            push_group_bytes(group_acc, 4);
            group_acc = '0;
            group_cnt = '0;
         end
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            decode_word(char_words.pop_front());
         end
         if (!req_if.valid || req_if.ready) begin
            if (char_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_if.valid     <= 1'b1;
               req_if.mode      <= char_words[0].mode;
               req_if.char_code <= char_words[0].char_code;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      byte_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("byte %02h with nothing expected", rsp_if.data_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_if.data_byte !== want.data_byte) begin
                  report_mismatch($sformatf("data_byte %02h, want %02h",
                                            rsp_if.data_byte, want.data_byte));
               end
               if (rsp_if.last_of_run !== want.last_of_run) begin
                  report_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
                                            rsp_if.last_of_run, want.last_of_run,
                                            want.data_byte));
               end
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // cycles with work outstanding but no word moving
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (char_words.size() != 0 || expected_bytes.size() != 0) begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no progress, %0d bytes still expected", $realtime,
               expected_bytes.size());
      $display("ascii85_stream_decoder_tb: errors");
      $finish;
   end

   task automatic add_char(input logic [7:0] code);
      char_word_type w;
      w.mode      = a85_pkg::MODE_CHAR;
      w.char_code = code;
      char_words.push_back(w);
   endtask

   // char_code is junk on a flush and must be ignored
   task automatic add_flush();
      char_word_type w;
      w.mode      = a85_pkg::MODE_FLUSH;
      w.char_code = 8'($urandom_range(0, 255));
      char_words.push_back(w);
   endtask

   task automatic add_random_items(input int n);
      int added;
      int pick;
      int k;
      added = 0;
      while (added < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            for (int i = 0; i < 5; i++) add_char(8'($urandom_range(33, 117)));
            added += 5;
         end else if (pick < 72) begin
            add_char(a85_pkg::ZERO_CHAR);
            added += 1;
         end else if (pick < 87) begin
            k = $urandom_range(0, 4);
            for (int i = 0; i < k; i++) add_char(8'($urandom_range(33, 117)));
            add_flush();
            added += k + 1;
         end else begin
            // noise: codes from the whole byte range and stray end markers
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++) begin
               if ($urandom_range(0, 4) == 0) add_flush();
               else add_char(8'($urandom_range(0, 255)));
            end
            added += k;
         end
      end
   endtask

   task automatic wait_for_drain();
      while (char_words.size() != 0 || expected_bytes.size() != 0) @(negedge clock);
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.mode      = a85_pkg::MODE_CHAR;
      req_if.char_code = 8'd0;
      rsp_if.ready     = 1'b0;
      group_acc        = '0;
      group_cnt        = '0;
      error_count      = 0;
      quiet_cycles     = 0;
      send_idle_pct    = 8;
      recv_stall_pct   = 53;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // end marker with an empty group
      add_flush();
      // largest group value
      add_char("s"); add_char("8"); add_char("W"); add_char("-"); add_char("!");
      add_char(a85_pkg::ZERO_CHAR);
      // 'z' part way through a group
      add_char("!"); add_char("!"); add_char(a85_pkg::ZERO_CHAR);
      // four 'u' padded with a fifth wraps past 2^32
      add_char("u"); add_char("u"); add_char("u"); add_char("u"); add_flush();
      // codes below and far above the digit range
      add_char(8'h00); add_char(8'hFF); add_char("A"); add_flush();
      add_char("B"); add_flush();
      add_char("C"); add_char("D"); add_flush();
      wait_for_drain();

      add_random_items(67);
      wait_for_drain();

      send_idle_pct  = 53;
      recv_stall_pct = 8;
      add_random_items(67);
      wait_for_drain();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      add_random_items(66);
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ascii85_stream_decoder_tb: clean");
      end else begin
         $display("ascii85_stream_decoder_tb: errors");
      end
      $finish;
   end

endmodule
